// ===== rtl/core/gfti_pkg.sv =====
// ----------------------------------------------------------------------------
// gfti_pkg: shared types and tables for the grid fan triangle indexer
// Neighbour codes, fan shapes, register indexes and the triangle order table.
// ----------------------------------------------------------------------------
package gfti_pkg;

  localparam int IDX_W     = 24;
  localparam int REG_W     = 13;
  localparam int POS_W     = 12;
  localparam int CFG_IDX_W = 8;
  localparam int STEP_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 8'd1;

  // Shape of the fan around a centre
  typedef enum logic [1:0] {
    FAN_INTERIOR = 2'd0,
    FAN_LAST_ROW = 2'd1,
    FAN_LAST_COL = 2'd2,
    FAN_CORNER   = 2'd3
  } fan_t;

  // Neighbours of a centre: upper, centre and lower rows
  typedef enum logic [2:0] {
    NB_UL = 3'd0,
    NB_UC = 3'd1,
    NB_UR = 3'd2,
    NB_CL = 3'd3,
    NB_CR = 3'd4,
    NB_LL = 3'd5,
    NB_LC = 3'd6,
    NB_LR = 3'd7
  } nb_t;

  typedef struct packed {
    nb_t  b;
    nb_t  c;
    logic last;
  } tri_sel_t;

  // One fan centre request handed from the index pipeline to the emitter
  typedef struct packed {
    fan_t             fan;
    logic [IDX_W-1:0] ctr;
    logic [IDX_W-1:0] uc;
    logic [IDX_W-1:0] lc;
  } gfti_item_t;

  function automatic tri_sel_t mk(nb_t b, nb_t c, logic last);
    tri_sel_t t;
    t.b    = b;
    t.c    = c;
    t.last = last;
    return t;
  endfunction

  // Triangle order for each fan shape
  function automatic tri_sel_t tri_of(fan_t fan, logic [STEP_W-1:0] step);
    tri_sel_t t;
    t = mk(NB_UL, NB_CL, 1'b1);
    case (step)
      3'd0: t = mk(NB_UL, NB_CL, 1'b0);
      3'd1: t = mk(NB_UC, NB_UL, fan == FAN_CORNER);
      3'd2: begin
        case (fan)
          FAN_LAST_ROW: t = mk(NB_CR, NB_UR, 1'b0);
          FAN_LAST_COL: t = mk(NB_CL, NB_LL, 1'b0);
          default:      t = mk(NB_UR, NB_UC, 1'b0);
        endcase
      end
      3'd3: begin
        case (fan)
          FAN_LAST_ROW: t = mk(NB_UR, NB_UC, 1'b1);
          FAN_LAST_COL: t = mk(NB_LL, NB_LC, 1'b1);
          default:      t = mk(NB_CR, NB_UR, 1'b0);
        endcase
      end
      3'd4: t = mk(NB_LR, NB_CR, 1'b0);
      3'd5: t = mk(NB_LC, NB_LR, 1'b0);
      3'd6: t = mk(NB_LL, NB_LC, 1'b0);
      3'd7: t = mk(NB_CL, NB_LL, 1'b1);
      default: t = mk(NB_UL, NB_CL, 1'b1);
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/gfti_front.sv =====
// ----------------------------------------------------------------------------
// gfti_front: index pipeline
// Three stages: qualify the position, form the centre index, form the
// indexes of the rows above and below. Stalls from the emitter backward.
// ----------------------------------------------------------------------------
module gfti_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [gfti_pkg::POS_W-1:0]  row,
  input  logic [gfti_pkg::POS_W-1:0]  col,
  input  logic [gfti_pkg::REG_W-1:0]  grid_w,
  input  logic [gfti_pkg::REG_W-1:0]  grid_h,
  output logic                        item_valid,
  output gfti_pkg::gfti_item_t        item,
  input  logic                        item_take
);
  import gfti_pkg::*;

  logic             s1_valid;
  logic [POS_W-1:0] s1_row;
  logic [POS_W-1:0] s1_col;
  logic [REG_W-1:0] s1_w;
  fan_t             s1_fan;

  logic             s2_valid;
  logic [IDX_W-1:0] s2_ctr;
  logic [REG_W-1:0] s2_w;
  fan_t             s2_fan;

  logic             s3_valid;
  gfti_item_t       s3_item;

  logic             en1, en2, en3;
  logic             fan_hit;
  logic             last_row, last_col;
  fan_t             fan_next;
  logic [IDX_W:0]   ctr_full;

  // Advance enables, from the emitter backward
  assign en3  = !s3_valid || item_take;
  assign en2  = !s2_valid || en3;
  assign en1  = !s1_valid || en2;
  assign busy = !en1;

  // Qualify the position: inside the grid with odd row and column
  always_comb begin
    fan_hit  = ({1'b0, row} < grid_h) && ({1'b0, col} < grid_w) && row[0] && col[0];
    last_row = ({1'b0, row} == grid_h - 13'd1);
    last_col = ({1'b0, col} == grid_w - 13'd1);
    case ({last_row, last_col})
      2'b10:   fan_next = FAN_LAST_ROW;
      2'b01:   fan_next = FAN_LAST_COL;
      2'b11:   fan_next = FAN_CORNER;
      default: fan_next = FAN_INTERIOR;
    endcase
  end

  // Centre index, taken modulo the index width
  assign ctr_full = (IDX_W+1)'(s1_row) * (IDX_W+1)'(s1_w) + (IDX_W+1)'(s1_col);

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= start && fan_hit;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_row <= row;
      s1_col <= col;
      s1_w   <= grid_w;
      s1_fan <= fan_next;
    end
    if (en2) begin
      s2_ctr <= ctr_full[IDX_W-1:0];
      s2_w   <= s1_w;
      s2_fan <= s1_fan;
    end
    if (en3) begin
      s3_item.fan <= s2_fan;
      s3_item.ctr <= s2_ctr;
      s3_item.uc  <= s2_ctr - IDX_W'(s2_w);
      s3_item.lc  <= s2_ctr + IDX_W'(s2_w);
    end
  end

  assign item_valid = s3_valid;
  assign item       = s3_item;

endmodule

// ===== rtl/core/gfti_emit.sv =====
// ----------------------------------------------------------------------------
// gfti_emit: triangle emitter
// Holds one fan centre with its eight neighbours and issues its triangles,
// one per cycle, through a registered result stage.
// ----------------------------------------------------------------------------
module gfti_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  gfti_pkg::gfti_item_t        item,
  output logic                        item_take,
  output logic                        result_valid,
  output logic [gfti_pkg::IDX_W-1:0]  vertex_a,
  output logic [gfti_pkg::IDX_W-1:0]  vertex_b,
  output logic [gfti_pkg::IDX_W-1:0]  vertex_c,
  output logic                        last_triangle
);
  import gfti_pkg::*;

  logic              e_valid;
  logic [STEP_W-1:0] step;
  fan_t              fan;
  logic [IDX_W-1:0]  ctr;
  logic [IDX_W-1:0]  nb [8];
  tri_sel_t          sel;

  // Pick the current triangle; free the slot on the final one
  always_comb begin
    sel       = tri_of(fan, step);
    item_take = !e_valid || sel.last;
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid      <= 1'b0;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= e_valid;
      if (item_take) begin
        e_valid <= item_valid;
        step    <= '0;
      end else begin
        step <= step + 3'd1;
      end
    end
  end

  // Load a new centre and its neighbours
  always_ff @(posedge clk) begin
    if (item_take && item_valid) begin
      fan       <= item.fan;
      ctr       <= item.ctr;
      nb[NB_UL] <= item.uc - 24'd1;
      nb[NB_UC] <= item.uc;
      nb[NB_UR] <= item.uc + 24'd1;
      nb[NB_CL] <= item.ctr - 24'd1;
      nb[NB_CR] <= item.ctr + 24'd1;
      nb[NB_LL] <= item.lc - 24'd1;
      nb[NB_LC] <= item.lc;
      nb[NB_LR] <= item.lc + 24'd1;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (e_valid) begin
      vertex_a      <= ctr;
      vertex_b      <= nb[sel.b];
      vertex_c      <= nb[sel.c];
      last_triangle <= sel.last;
    end
  end

endmodule

// ===== rtl/core/grid_fan_triangle_indexer_core.sv =====
// ----------------------------------------------------------------------------
// grid_fan_triangle_indexer_core: fan triangle indexes for a vertex grid
// Configuration registers, index pipeline and triangle emitter.
// ----------------------------------------------------------------------------
// A position is taken whenever start is high and busy is low; busy rises only
// while the emitter is still issuing an earlier fan. Positions that are not
// fan centres are taken and give nothing. A fan centre gives 8, 4 or 2
// triangles (interior, last row or last column, corner), one triangle per
// cycle; about a quarter of the vertices are centres. The first triangle
// passes through the index stages, the emitter slot and the result
// register. Results leave on result_valid for one cycle each and are never
// held back: the receiver must take every one as it comes.
module grid_fan_triangle_indexer_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [gfti_pkg::POS_W-1:0]     row,
  input  logic [gfti_pkg::POS_W-1:0]     col,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gfti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gfti_pkg::REG_W-1:0]     cfg_data,
  output logic                           result_valid,
  output logic [gfti_pkg::IDX_W-1:0]     vertex_a,
  output logic [gfti_pkg::IDX_W-1:0]     vertex_b,
  output logic [gfti_pkg::IDX_W-1:0]     vertex_c,
  output logic                           last_triangle
);
  import gfti_pkg::*;

  logic [REG_W-1:0] grid_width;
  logic [REG_W-1:0] grid_height;
  logic             item_valid;
  gfti_item_t       item;
  logic             item_take;

  assign cfg_ready = 1'b1;

  // Hold the grid size, clamped to the supported maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 13'd2;
      grid_height <= 13'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH: begin
          if (32'(cfg_data) > MAX_WIDTH) grid_width <= REG_W'(MAX_WIDTH);
          else grid_width <= cfg_data;
        end
        CFG_GRID_HEIGHT: begin
          if (32'(cfg_data) > MAX_HEIGHT) grid_height <= REG_W'(MAX_HEIGHT);
          else grid_height <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  gfti_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .row        (row),
    .col        (col),
    .grid_w     (grid_width),
    .grid_h     (grid_height),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  gfti_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take),
    .result_valid  (result_valid),
    .vertex_a      (vertex_a),
    .vertex_b      (vertex_b),
    .vertex_c      (vertex_c),
    .last_triangle (last_triangle)
  );

endmodule

// ===== verif/grid_fan_triangle_indexer_core_test.sv =====
// ----------------------------------------------------------------------------
// grid_fan_triangle_indexer_core_test: self-checking bench for the fan indexer
// Drives grid positions under several grid sizes and predicts every fan
// triangle. Each triangle on the result port is checked in order, field by
// field. Covers sizes at and above the limit, tiny grids and a spare index.
// ----------------------------------------------------------------------------
module grid_fan_triangle_indexer_core_test;
  import gfti_pkg::*;

  localparam int MAX_W         = 4096;
  localparam int MAX_H         = 4096;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 42;

  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'hFF;

  typedef struct {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic             last;
  } triangle_t;

  // Fan predictor and triangle store
  class fan_scoreboard;
    logic [REG_W-1:0] grid_w;
    logic [REG_W-1:0] grid_h;
    triangle_t        triangle_q[$];
    int               errors;

    function new();
      grid_w = 13'd2;
      grid_h = 13'd2;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
      if (idx == CFG_GRID_WIDTH) begin
        grid_w = data;
      end else if (idx == CFG_GRID_HEIGHT) begin
        grid_h = data;
      end
    endfunction

    function void add_triangle(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                               logic [IDX_W-1:0] c);
      triangle_t t;
      t.a    = a;
      t.b    = b;
      t.c    = c;
      t.last = 1'b0;
      triangle_q.insert(triangle_q.size(), t);
    endfunction

    // Work out the fan of one accepted position
    function void note_request(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
      logic [REG_W-1:0] w;
      logic [REG_W-1:0] h;
      logic [IDX_W-1:0] ctr;
      logic [IDX_W-1:0] uc;
      logic [IDX_W-1:0] lc;
      logic             last_row;
      logic             last_col;
      w = (grid_w > MAX_W) ? REG_W'(MAX_W) : grid_w;
      h = (grid_h > MAX_H) ? REG_W'(MAX_H) : grid_h;
      if (REG_W'(r) >= h || REG_W'(c) >= w) return;
      if (!r[0] || !c[0]) return;
      ctr      = IDX_W'(r) * IDX_W'(w) + IDX_W'(c);
      uc       = ctr - IDX_W'(w);
      lc       = ctr + IDX_W'(w);
      last_row = (REG_W'(r) + 13'd1 == h);
      last_col = (REG_W'(c) + 13'd1 == w);
      add_triangle(ctr, uc - 24'd1, ctr - 24'd1);
      add_triangle(ctr, uc, uc - 24'd1);
      if (last_row && !last_col) begin
        add_triangle(ctr, ctr + 24'd1, uc + 24'd1);
        add_triangle(ctr, uc + 24'd1, uc);
      end else if (!last_row && last_col) begin
        add_triangle(ctr, ctr - 24'd1, lc - 24'd1);
        add_triangle(ctr, lc - 24'd1, lc);
      end else if (!last_row && !last_col) begin
        add_triangle(ctr, uc + 24'd1, uc);
        add_triangle(ctr, ctr + 24'd1, uc + 24'd1);
        add_triangle(ctr, lc + 24'd1, ctr + 24'd1);
        add_triangle(ctr, lc, lc + 24'd1);
        add_triangle(ctr, lc - 24'd1, lc);
        add_triangle(ctr, ctr - 24'd1, lc - 24'd1);
      end
      triangle_q[triangle_q.size() - 1].last = 1'b1;
    endfunction

    // Compare one emitted triangle with the oldest prediction
    function void check_triangle(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                 logic [IDX_W-1:0] c, logic last);
      triangle_t t;
      if (triangle_q.size() == 0) begin
        $error("unexpected triangle (%0d, %0d, %0d) last %0b", a, b, c, last);
        errors++;
        return;
      end
      t = triangle_q.pop_front();
      if (a !== t.a) begin
        $error("vertex_a: expected %0d, got %0d", t.a, a);
        errors++;
      end
      if (b !== t.b) begin
        $error("vertex_b: expected %0d, got %0d", t.b, b);
        errors++;
      end
      if (c !== t.c) begin
        $error("vertex_c: expected %0d, got %0d", t.c, c);
        errors++;
      end
      if (last !== t.last) begin
        $error("last_triangle: expected %0b, got %0b", t.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return triangle_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [POS_W-1:0]     row;
  logic [POS_W-1:0]     col;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 result_valid;
  logic [IDX_W-1:0]     vertex_a;
  logic [IDX_W-1:0]     vertex_b;
  logic [IDX_W-1:0]     vertex_c;
  logic                 last_triangle;

  fan_scoreboard fans = new();
  int            quiet_cycles = 0;

  grid_fan_triangle_indexer_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .row          (row),
    .col          (col),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .vertex_c     (vertex_c),
    .last_triangle(last_triangle)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Observe handshakes, check triangles and guard against a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) fans.write_reg(cfg_index, cfg_data);
      if (start && !busy) fans.note_request(row, col);
      if (result_valid) fans.check_triangle(vertex_a, vertex_b, vertex_c, last_triangle);
      if ((cfg_valid && cfg_ready) || (start && !busy) || result_valid) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offer one position and hold it until taken
  task automatic send_request(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
    start <= 1'b1;
    row   <= r;
    col   <= c;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Write one register; keep valid high when another write follows
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [REG_W-1:0] data, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every predicted triangle has come, then settle
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (fans.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
    wait_drained();
    write_register(CFG_GRID_WIDTH, w, 1'b1);
    write_register(CFG_GRID_HEIGHT, h, 1'b0);
  endtask

  // Odd coordinate below n, weighted towards the last one
  function automatic logic [POS_W-1:0] odd_below(input int n);
    if ($urandom_range(0, 3) == 0) return POS_W'((n % 2 == 0) ? n - 1 : n - 2);
    return POS_W'($urandom_range(0, (n - 2) / 2) * 2 + 1);
  endfunction

  // Random positions under one grid size: mostly fan centres, some noise
  task automatic run_phase(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h,
                           input bit idling);
    int               eff_w;
    int               eff_h;
    int               pick;
    logic [POS_W-1:0] r;
    logic [POS_W-1:0] c;
    set_grid(w, h);
    eff_w = (w > MAX_W) ? MAX_W : w;
    eff_h = (h > MAX_H) ? MAX_H : h;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (idling && $urandom_range(0, 99) < 30) idle_sender($urandom_range(1, 7));
      if (idling && $urandom_range(0, 99) < 3) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        r = odd_below(eff_h);
        c = odd_below(eff_w);
      end else if (pick < 80) begin
        r = POS_W'($urandom_range(0, eff_h - 1));
        c = POS_W'($urandom_range(0, eff_w - 1));
      end else begin
        r = POS_W'($urandom_range(0, 4095));
        c = POS_W'($urandom_range(0, 4095));
      end
      send_request(r, c);
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    row       = '0;
    col       = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset grid of two by two: a single corner centre
    send_request(12'd1, 12'd1);
    send_request(12'd0, 12'd0);
    send_request(12'd1, 12'd0);

    // Four by four: every fan shape, an even row and positions just outside
    set_grid(13'd4, 13'd4);
    send_request(12'd1, 12'd1);
    send_request(12'd3, 12'd1);
    send_request(12'd1, 12'd3);
    send_request(12'd3, 12'd3);
    send_request(12'd2, 12'd1);
    send_request(12'd4, 12'd1);
    send_request(12'd1, 12'd4);

    // Oversized registers clamp to the limit; largest indexes
    set_grid(13'd8191, 13'd8191);
    send_request(12'd4095, 12'd4095);
    send_request(12'd4095, 12'd1);
    send_request(12'd1, 12'd4095);
    send_request(12'd4093, 12'd4093);
    send_request(12'd4095, 12'd4094);
    send_request(12'd0, 12'd0);

    // Tiny grids leave no centre; a write to a spare index changes nothing
    set_grid(13'd0, 13'd5);
    send_request(12'd1, 12'd1);
    send_request(12'd0, 12'd0);
    wait_drained();
    write_register(CFG_GRID_WIDTH, 13'd1, 1'b1);
    write_register(CFG_GRID_HEIGHT, 13'd1, 1'b1);
    write_register(CFG_SPARE, 13'h1FFF, 1'b0);
    send_request(12'd0, 12'd0);
    send_request(12'd1, 12'd1);

    run_phase(13'd4096, 13'd4096, 1'b1);
    run_phase(REG_W'($urandom_range(2, 12)), REG_W'($urandom_range(2, 12)), 1'b1);
    run_phase(REG_W'($urandom_range(2, 400)), REG_W'($urandom_range(2, 400)), 1'b1);
    run_phase(REG_W'($urandom_range(4097, 8191)), REG_W'($urandom_range(2, 64)), 1'b1);
    run_phase(REG_W'($urandom_range(2, 12)), REG_W'($urandom_range(2, 12)), 1'b0);

    wait_drained();
    if (fans.errors == 0 && fans.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
